### sv/modexp_pkg.sv
package modexp_pkg;
   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CSR_MODULUS  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_EXPONENT = 1'b1;

   // one slot of the modular multiply cell chain
   typedef struct packed {
      logic busy;
      logic last;
   } cell_ctl_type;
endpackage

### sv/modular_exponentiation.sv
// channel | dir | fields
// req     | in  | tdata[15:0] residue
// rsp     | out | tdata[15:0] power_mod
// csr     | in  | index 0 modulus, index 1 exponent
// Per word: 1 reduce multiply plus up to 2*OPERAND_WIDTH multiplies, each
// passing through the cell row in turn.
// Zero exponent or modulus below two skips the multiplies and goes to output.
// One word at a time; req_tready drops while busy or while rsp holds a word.
// Synchronous active-high reset returns modulus 2 and exponent 1.
module modular_exponentiation import modexp_pkg::*; #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // residue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // power_mod
   input  logic        csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int W = OPERAND_WIDTH;
   localparam int BW = $clog2(W);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_BASE = 3'd1, ST_SQR = 3'd2,
                          ST_MUL = 3'd3, ST_OUT = 3'd4;

   logic [2:0]    state_ff;
   logic [W-1:0]  mod_ff, exp_ff, base_ff, acc_ff;
   logic [BW-1:0] bit_ff;
   logic          wait_ff;
   logic          mstart;
   logic [W-1:0]  ma, mb;
   logic          mdone;
   logic [W-1:0]  mprod;
   logic [15:0]   out_ff;
   logic          ovalid_ff;

   modexp_mul #(.W(W)) u_mul (
      .clock, .reset, .start(mstart), .a(ma), .b(mb), .m(mod_ff),
      .done(mdone), .prod(mprod)
   );

   // base load multiplies residue by 1 to reduce it
   always_comb begin
      mstart = 1'b0;
      ma = acc_ff;
      mb = acc_ff;
      if (state_ff == ST_BASE && !wait_ff) begin
         mstart = 1'b1; ma = base_ff; mb = W'(1);
      end else if (state_ff == ST_SQR && !wait_ff) begin
         mstart = 1'b1;
      end else if (state_ff == ST_MUL && !wait_ff) begin
         mstart = 1'b1; mb = base_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mod_ff <= W'(2);
         exp_ff <= W'(1);
         wait_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_MODULUS) mod_ff <= W'(csr_wdata);
         if (csr_we && csr_index == CSR_EXPONENT) exp_ff <= W'(csr_wdata);
         if (ovalid_ff && rsp_tready) ovalid_ff <= 1'b0;
         if (mstart) wait_ff <= 1'b1;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && !ovalid_ff) begin
                  base_ff <= W'(req_tdata);
                  acc_ff <= W'(1);
                  bit_ff <= BW'(W-1);
                  if (mod_ff < W'(2)) begin
                     acc_ff <= '0; state_ff <= ST_OUT;
                  end else if (exp_ff == '0) begin
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_BASE;
                  end
               end
            end
            ST_BASE: if (mdone) begin
               wait_ff <= 1'b0; base_ff <= mprod; state_ff <= ST_SQR;
            end
            ST_SQR: if (mdone) begin
               wait_ff <= 1'b0; acc_ff <= mprod;
               if (exp_ff[bit_ff]) state_ff <= ST_MUL;
               else if (bit_ff == '0) state_ff <= ST_OUT;
               else bit_ff <= bit_ff - 1'b1;
            end
            ST_MUL: if (mdone) begin
               wait_ff <= 1'b0; acc_ff <= mprod;
               if (bit_ff == '0) state_ff <= ST_OUT;
               else begin
                  bit_ff <= bit_ff - 1'b1; state_ff <= ST_SQR;
               end
            end
            ST_OUT: begin
               out_ff <= 16'(acc_ff);
               ovalid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

### sv/modexp_cell.sv
// One radix-2 step of an interleaved modular multiply: acc = 2*acc + bit*b mod m.
// The cell takes one multiplier bit and registers the running sum for its neighbor.
module modexp_cell import modexp_pkg::*; #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic         in_bit,
   input  logic [W-1:0] in_acc,
   input  logic [W-1:0] b,
   input  logic [W-1:0] m,
   output logic         out_valid,
   output logic [W-1:0] out_acc
);
   logic         valid_ff;
   logic [W-1:0] acc_ff, acc_in;
   logic [W+1:0] dbl, t1, t2;

   always_comb begin
      dbl = {1'b0, in_acc, 1'b0};
      t1 = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
      t2 = t1 + (in_bit ? {2'b00, b} : '0);
      if (t2 >= {2'b00, m}) t2 = t2 - {2'b00, m};
      acc_in = t2[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      acc_ff <= acc_in;
   end

   assign out_valid = valid_ff;
   assign out_acc = acc_ff;
endmodule

### sv/modexp_mul.sv
// Modular multiply a*b mod m as a row of W cells, one per bit of a, MSB first.
module modexp_mul import modexp_pkg::*; #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] prod
);
   logic [W:0]   v;
   logic [W-1:0] acc [W+1];
   logic [W-1:0] a_ff, b_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
   end

   assign v[0] = start;
   assign acc[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      modexp_cell #(.W(W)) u_cell (
         .clock, .reset,
         .in_valid(v[i]),
         .in_bit(i == 0 ? a[W-1] : a_ff[W-1-i]),
         .in_acc(acc[i]),
         .b(i == 0 ? b : b_ff),
         .m,
         .out_valid(v[i+1]),
         .out_acc(acc[i+1])
      );
   end

   assign done = v[W];
   assign prod = acc[W];
endmodule
